@@ design/arsn_pkg.sv @@
// ----------------------------------------------------------------------------
// arsn_pkg
// Types and constants shared by the status notifier modules.
// ----------------------------------------------------------------------------
package arsn_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_FILL  = 3'd1;
  localparam logic [2:0] CMD_EMPTY = 3'd2;
  localparam logic [2:0] CMD_WAKE  = 3'd3;
  localparam logic [2:0] CMD_RX    = 3'd4;

  // phase codes
  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_WAIT_FULL  = 2'd1;
  localparam logic [1:0] PH_WAIT_EMPTY = 2'd2;

  // register indexes
  localparam logic [2:0] REG_RETRY_INTERVAL = 3'd0;
  localparam logic [2:0] REG_MAX_RETRIES    = 3'd1;
  localparam logic [2:0] REG_ACK_CODE       = 3'd2;
  localparam logic [2:0] REG_FULL_CODE      = 3'd3;
  localparam logic [2:0] REG_EMPTY_CODE     = 3'd4;

  // register reset values
  localparam logic [15:0] RST_RETRY_INTERVAL = 16'd1000;
  localparam logic [3:0]  RST_MAX_RETRIES    = 4'd5;
  localparam logic [7:0]  RST_ACK_CODE       = 8'h25;
  localparam logic [7:0]  RST_FULL_CODE      = 8'h55;
  localparam logic [7:0]  RST_EMPTY_CODE     = 8'hAA;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // one result beat
  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_code;
    logic       status_full;
    logic [1:0] waiting;
    logic [3:0] retry_count;
  } result_t;

endpackage

@@ design/arsn_ctrl.sv @@
// ----------------------------------------------------------------------------
// arsn_ctrl
// Configuration registers, notifier state and the per-item update logic.
// ----------------------------------------------------------------------------
module arsn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             step,
  input  logic [2:0]       command,
  input  logic [7:0]       rx_byte,
  output arsn_pkg::result_t result
);
  import arsn_pkg::*;

  logic [15:0] retry_interval;
  logic [3:0]  max_retries;
  logic [7:0]  ack_code;
  logic [7:0]  full_code;
  logic [7:0]  empty_code;

  logic [1:0]  phase, phase_next;
  logic        box_full, box_full_next;
  logic        ack_seen, ack_seen_next;
  logic [15:0] elapsed, elapsed_next;
  logic [3:0]  retries, retries_next;
  logic        send_valid;
  logic [7:0]  send_code;
  logic        waiting;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval <= RST_RETRY_INTERVAL;
      max_retries    <= RST_MAX_RETRIES;
      ack_code       <= RST_ACK_CODE;
      full_code      <= RST_FULL_CODE;
      empty_code     <= RST_EMPTY_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RETRY_INTERVAL: retry_interval <= cfg_data;
        REG_MAX_RETRIES:    max_retries    <= cfg_data[3:0];
        REG_ACK_CODE:       ack_code       <= cfg_data[7:0];
        REG_FULL_CODE:      full_code      <= cfg_data[7:0];
        REG_EMPTY_CODE:     empty_code     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign waiting = (phase == PH_WAIT_FULL) || (phase == PH_WAIT_EMPTY);

  // next state and result for the current item
  always_comb begin
    phase_next    = waiting ? phase : PH_IDLE;
    box_full_next = box_full;
    ack_seen_next = ack_seen;
    elapsed_next  = elapsed;
    retries_next  = retries;
    send_valid    = 1'b0;
    send_code     = 8'h00;
    case (command)
      CMD_TICK: begin
        if (waiting) begin
          if (ack_seen) begin
            ack_seen_next = 1'b0;
            box_full_next = (phase == PH_WAIT_FULL);
            phase_next    = PH_IDLE;
            retries_next  = 4'd0;
            elapsed_next  = 16'd0;
          end else begin
            if ((elapsed >= retry_interval) && (retries < max_retries)) begin
              send_valid   = 1'b1;
              send_code    = (phase == PH_WAIT_FULL) ? full_code : empty_code;
              retries_next = retries + 4'd1;
              elapsed_next = 16'd0;
            end else if (elapsed != ELAPSED_MAX) begin
              elapsed_next = elapsed + 16'd1;
            end
            // retry budget spent: commit without ack
            if (retries_next >= max_retries) begin
              box_full_next = (phase == PH_WAIT_FULL);
              phase_next    = PH_IDLE;
              retries_next  = 4'd0;
              elapsed_next  = 16'd0;
            end
          end
        end
      end
      CMD_FILL: begin
        if (!waiting) begin
          if (!box_full) begin
            send_valid   = 1'b1;
            send_code    = full_code;
            phase_next   = PH_WAIT_FULL;
            elapsed_next = 16'd0;
          end
          retries_next = 4'd0;
        end
      end
      CMD_EMPTY: begin
        if (!waiting) begin
          if (box_full) begin
            send_valid   = 1'b1;
            send_code    = empty_code;
            phase_next   = PH_WAIT_EMPTY;
            elapsed_next = 16'd0;
          end
          retries_next = 4'd0;
        end
      end
      CMD_RX: begin
        if (rx_byte == ack_code) ack_seen_next = 1'b1;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      box_full <= 1'b0;
      ack_seen <= 1'b0;
      elapsed  <= 16'd0;
      retries  <= 4'd0;
    end else if (step) begin
      phase    <= phase_next;
      box_full <= box_full_next;
      ack_seen <= ack_seen_next;
      elapsed  <= elapsed_next;
      retries  <= retries_next;
    end
  end

  // result after the update
  always_comb begin
    result.send_valid  = send_valid;
    result.send_code   = send_code;
    result.status_full = box_full_next;
    result.waiting     = phase_next;
    result.retry_count = retries_next;
  end

`ifndef ASSERT_OFF
  // unused phase code is never reached
  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("phase reached unused code");

  // no resends are counted outside a wait
  a_idle_retries: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (retries == 4'd0))
    else $error("retries nonzero while idle");

  // a tick that finds an ack ends the wait and clears the flag
  a_ack_commit: assert property (@(posedge clk) disable iff (rst)
    (step && (command == CMD_TICK) && waiting && ack_seen)
      |=> (!ack_seen && (phase == PH_IDLE)))
    else $error("ack did not commit the status");

  // a send only ever leaves the full or empty code
  a_send_code: assert property (@(posedge clk) disable iff (rst)
    send_valid |-> ((send_code == full_code) || (send_code == empty_code)))
    else $error("unexpected send code");
`endif

endmodule

@@ design/arsn_obuf.sv @@
// ----------------------------------------------------------------------------
// arsn_obuf
// Result register towards the output channel, held while the receiver stalls.
// ----------------------------------------------------------------------------
module arsn_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  arsn_pkg::result_t result,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output arsn_pkg::result_t held
);
  import arsn_pkg::*;

  logic valid_q;

  // slot can take a new beat when empty or being drained
  assign free      = !valid_q || !out_stall;
  assign out_valid = valid_q;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

@@ design/ack_retry_status_notifier.sv @@
// ----------------------------------------------------------------------------
// ack_retry_status_notifier
// Status change notifier with acknowledgement, resend and forced commit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command per beat: tick,
//   fill event, empty event, other wake or received byte (rx_byte).
//   Output channel (out_valid/out_stall) gives exactly one result beat per
//   input beat, in order: send request and code, committed status, wait
//   phase and resend count, all as they stand after that command.
//   Configuration: cfg_we with cfg_index/cfg_data writes a register;
//   write only while no beats are in flight.
// Timing:
//   A beat is held in the input register while the update logic works on
//   it, and moves into the result register when that register is free,
//   which raises out_valid. One beat per cycle is sustained while out_stall
//   is low; the state update is a single pass of small-register logic.
// Reset (rst, synchronous): registers take their defaults, the box reads
//   empty, the block is idle and both channels are empty.
// Stall: a stalled result holds; the input register keeps one more beat,
//   then in_stall rises until the receiver takes the result.
// ----------------------------------------------------------------------------
module ack_retry_status_notifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_valid,
  output logic [7:0]  send_code,
  output logic        status_full,
  output logic [1:0]  waiting,
  output logic [3:0]  retry_count
);
  import arsn_pkg::*;

  logic       in_v;
  logic [2:0] cmd_q;
  logic [7:0] rx_q;
  logic       out_free;
  logic       step;
  logic       accept;
  result_t    result;
  result_t    held;

  // input register handshake
  assign step     = in_v && out_free;
  assign in_stall = in_v && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (accept) begin
      in_v <= 1'b1;
    end else if (step) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      rx_q  <= rx_byte;
    end
  end

  // state update
  arsn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .command   (cmd_q),
    .rx_byte   (rx_q),
    .result    (result)
  );

  // result register
  arsn_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .result    (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign send_valid  = held.send_valid;
  assign send_code   = held.send_code;
  assign status_full = held.status_full;
  assign waiting     = held.waiting;
  assign retry_count = held.retry_count;

endmodule
